// ===== rtl/lphd_pkg.sv =====
// Shared types, codes and helper functions for the linear probing hash dictionary.
package lphd_pkg;

	localparam int TABLE_SLOTS  = 26;
	localparam int SLOT_W       = $clog2(TABLE_SLOTS);
	localparam int KEY_W        = 64;
	localparam int VALUE_W      = 64;
	localparam int CHAR_W       = 8;
	localparam int KEY_CHARS_DEF = 8;

	localparam logic [CHAR_W-1:0] LOWER_A     = 8'd97;
	localparam logic [CHAR_W-1:0] UPPER_A     = 8'd65;
	localparam logic [CHAR_W-1:0] NUM_LETTERS = 8'd26;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_MISSING    = 2'd2,
		ST_NOT_LETTER = 2'd3
	} status_t;

	typedef struct packed {
		logic  letter;
		slot_t slot;
	} home_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    load;
		logic    evict;
		logic    store;
		logic    clear;
		logic    advance;
		logic    post;
		status_t code;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		mode_t mode;
		logic  letter;
		logic  slot_free;
		logic  hit;
		logic  evict;
		logic  last;
		logic  out_free;
	} dp_stat_t;

	// Home slot of a first character, case folded; letter low if not a letter
	function automatic home_t home_of(input logic [CHAR_W-1:0] ch);
		home_t            h;
		logic [CHAR_W-1:0] d;
		h = '0;
		d = '0;
		if (ch >= LOWER_A && ch < LOWER_A + NUM_LETTERS) begin
			d = ch - LOWER_A;
			h.letter = 1'b1;
		end else if (ch >= UPPER_A && ch < UPPER_A + NUM_LETTERS) begin
			d = ch - UPPER_A;
			h.letter = 1'b1;
		end
		h.slot = d[SLOT_W-1:0];
		return h;
	endfunction

	// Next probe slot with wrap
	function automatic slot_t next_slot(input slot_t p);
		return (p == slot_t'(TABLE_SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ===== rtl/lphd_datapath.sv =====
// Datapath: slot storage, probe pointer, input and result registers.
module lphd_datapath #(
	parameter int KEY_CHARS = lphd_pkg::KEY_CHARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lphd_pkg::ctl_cmd_t            cmd,
	output lphd_pkg::dp_stat_t            stat,
	input  logic [1:0]                    mode,
	input  logic [lphd_pkg::KEY_W-1:0]    key,
	input  logic [lphd_pkg::VALUE_W-1:0]  value,
	input  logic                          cfg_valid,
	input  logic                          replace_mode,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [1:0]                    status
);
	import lphd_pkg::*;

	localparam logic [KEY_W-1:0] KeyMask = {KEY_W{1'b1}} << (KEY_W - CHAR_W * KEY_CHARS);

	logic                replace_q;
	mode_t               mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  value_q;
	slot_t               home_q;
	logic                letter_q;
	slot_t               ptr_q;
	slot_t               cnt_q;
	logic [KEY_W-1:0]    slot_key_q   [TABLE_SLOTS];
	logic [VALUE_W-1:0]  slot_value_q [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] used_q;
	logic                out_valid_q;
	status_t             status_q;

	home_t               home_in;
	home_t               rd_home;
	logic [KEY_W-1:0]    rd_key;
	logic [VALUE_W-1:0]  rd_value;

	// Decode the incoming key and read the slot under the probe pointer
	assign home_in  = home_of(key[KEY_W-1 -: CHAR_W]);
	assign rd_key   = slot_key_q[ptr_q];
	assign rd_value = slot_value_q[ptr_q];
	assign rd_home  = home_of(rd_key[KEY_W-1 -: CHAR_W]);

	// Report probe conditions to the controller
	always_comb begin
		stat.mode      = mode_q;
		stat.letter    = letter_q;
		stat.slot_free = !used_q[ptr_q];
		stat.hit       = used_q[ptr_q] && (rd_key == key_q);
		stat.evict     = replace_q && used_q[ptr_q] &&
			!(rd_home.letter && (rd_home.slot == home_q));
		stat.last      = (cnt_q == slot_t'(TABLE_SLOTS - 1));
		stat.out_free  = !out_valid_q || out_ready;
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_q <= 1'b0;
		end else if (cfg_valid) begin
			replace_q <= replace_mode;
		end
	end

	// Set and clear slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.store) begin
			used_q[ptr_q] <= 1'b1;
		end else if (cmd.clear) begin
			used_q[ptr_q] <= 1'b0;
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Latch the item, swap on eviction, advance the probe
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode_t'(mode);
			key_q    <= key & KeyMask;
			value_q  <= value;
			home_q   <= home_in.slot;
			letter_q <= home_in.letter;
			ptr_q    <= home_in.slot;
			cnt_q    <= '0;
		end else if (cmd.evict) begin
			slot_key_q[ptr_q]   <= key_q;
			slot_value_q[ptr_q] <= value_q;
			key_q               <= rd_key;
			value_q             <= rd_value;
			ptr_q               <= next_slot(ptr_q);
		end else if (cmd.store) begin
			slot_key_q[ptr_q]   <= key_q;
			slot_value_q[ptr_q] <= value_q;
		end else if (cmd.advance) begin
			ptr_q <= next_slot(ptr_q);
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.post) begin
			status_q <= cmd.code;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !used_q[ptr_q])
		else $error("store into an occupied slot");

	a_clear_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> stat.hit)
		else $error("delete on a slot without a key match");

	a_evict_home: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> (ptr_q == home_q) && (cnt_q == '0))
		else $error("eviction away from the home slot");
`endif

endmodule

// ===== rtl/lphd_ctrl.sv =====
// Controller state machine that sequences decode, eviction, probing and result posting.
module lphd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lphd_pkg::dp_stat_t stat,
	output lphd_pkg::ctl_cmd_t cmd
);
	import lphd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_EVICT  = 6'b000100,
		S_PROBE  = 6'b001000,
		S_SCAN   = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t  state_q, state_d;
	status_t code_q, code_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		code_d      = code_q;
		cmd         = '0;
		cmd.code    = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.mode == MODE_NOP) begin
					code_d  = ST_OK;
					state_d = S_FIN;
				end else if (!stat.letter) begin
					code_d  = ST_NOT_LETTER;
					state_d = S_FIN;
				end else if (stat.mode == MODE_INSERT) begin
					state_d = S_EVICT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_EVICT: begin
				cmd.evict = stat.evict;
				state_d   = S_PROBE;
			end
			S_PROBE: begin
				if (stat.slot_free) begin
					cmd.store = 1'b1;
					code_d    = ST_OK;
					state_d   = S_FIN;
				end else if (stat.last) begin
					code_d  = ST_FULL;
					state_d = S_FIN;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.clear = (stat.mode == MODE_DELETE);
					code_d    = ST_OK;
					state_d   = S_FIN;
				end else if (stat.last) begin
					code_d  = ST_MISSING;
					state_d = S_FIN;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.post = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECODE))
		else $error("accepted item not decoded next cycle");

	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |-> stat.out_free)
		else $error("result posted over a waiting result");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");
`endif

endmodule

// ===== rtl/linear_probe_hash_dictionary.sv =====
// The result is registered after the controller states decode, home check (inserts only),
// probe or scan (one slot per cycle, set by the single slot compare, over up to 26 slots)
// and finish, which stalls until the output register is free. The next input is taken once
// the controller is idle, even while an earlier result still waits in the output register.
// Reset (arst_n, asynchronous): clears all occupancy flags, replace_mode and the result
// valid; slot keys and values are not cleared.
module linear_probe_hash_dictionary #(
	parameter int KEY_CHARS = lphd_pkg::KEY_CHARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [lphd_pkg::KEY_W-1:0]    key,
	input  logic [lphd_pkg::VALUE_W-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          replace_mode
);
	import lphd_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	lphd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lphd_datapath #(
		.KEY_CHARS (KEY_CHARS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.key          (key),
		.value        (value),
		.cfg_valid    (cfg_valid),
		.replace_mode (replace_mode),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status)
	);

endmodule
